@@ rtl/core/m31alu_pkg.sv @@
// Package with the types, constants, microcode and field arithmetic of the Mersenne-31 ALU.
`default_nettype none

package m31alu_pkg;

   localparam int FIELD_BITS = 31;
   localparam logic [30:0] MODULUS = {FIELD_BITS{1'b1}};
   localparam logic [30:0] INV_EXPONENT = MODULUS - 31'd2;
   localparam logic [4:0] INV_LAST_BIT = 5'(FIELD_BITS - 1);

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_NEG = 3'd3;
   localparam logic [2:0] OP_INV = 3'd4;
   localparam logic [2:0] OP_RED = 3'd5;
   localparam logic [2:0] OP_DOT = 3'd6;

   localparam logic [1:0] FAULT_NONE     = 2'd0;
   localparam logic [1:0] FAULT_INV_ZERO = 2'd1;
   localparam logic [1:0] FAULT_EQ_Q     = 2'd2;

   localparam logic [3:0] UA_IDLE          = 4'd0;
   localparam logic [3:0] UA_ADD           = 4'd1;
   localparam logic [3:0] UA_SUB           = 4'd2;
   localparam logic [3:0] UA_NEG           = 4'd3;
   localparam logic [3:0] UA_MUL           = 4'd4;
   localparam logic [3:0] UA_FOLD          = 4'd5;
   localparam logic [3:0] UA_DOT_MUL       = 4'd6;
   localparam logic [3:0] UA_DOT_FOLD      = 4'd7;
   localparam logic [3:0] UA_DOT_SUM       = 4'd8;
   localparam logic [3:0] UA_INV_INIT      = 4'd9;
   localparam logic [3:0] UA_INV_TOP       = 4'd10;
   localparam logic [3:0] UA_INV_MUL       = 4'd11;
   localparam logic [3:0] UA_INV_FOLD_ACC  = 4'd12;
   localparam logic [3:0] UA_INV_SQ        = 4'd13;
   localparam logic [3:0] UA_INV_FOLD_BASE = 4'd14;
   localparam logic [3:0] UA_INV_DONE      = 4'd15;

   typedef enum logic [1:0] {MUL_NONE, MUL_XY, MUL_ACC_BASE, MUL_BASE_BASE} mul_sel_type;
   typedef enum logic [1:0] {FOLD_NONE, FOLD_ACC, FOLD_BASE} fold_dst_type;
   typedef enum logic [1:0] {COND_NEXT, COND_ALWAYS, COND_BIT_CLEAR, COND_LAST_BIT} cond_type;
   typedef enum logic [2:0] {RES_ADD, RES_SUB, RES_NEG, RES_FOLD, RES_DOT, RES_ACC} res_sel_type;
   typedef enum logic [1:0] {EMIT_NONE, EMIT_ALWAYS, EMIT_IF_LAST} emit_type;

   typedef struct packed {
      mul_sel_type  mul_sel;
      fold_dst_type fold_dst;
      logic         inv_init;
      logic         cnt_inc;
      cond_type     cond;
      logic [3:0]   target;
      res_sel_type  res_sel;
      emit_type     emit;
      logic         sum_wr;
      logic         done;
   } ctrl_type;

   localparam ctrl_type CTRL_NOP = '{
      mul_sel: MUL_NONE, fold_dst: FOLD_NONE, inv_init: 1'b0, cnt_inc: 1'b0,
      cond: COND_NEXT, target: UA_IDLE, res_sel: RES_ADD, emit: EMIT_NONE,
      sum_wr: 1'b0, done: 1'b0};

   function automatic ctrl_type ucode_rom(input logic [3:0] addr);
      ctrl_type c;
      c = CTRL_NOP;
      unique case (addr)
         UA_IDLE: begin
         end
         UA_ADD: begin
            c.res_sel = RES_ADD;
            c.emit    = EMIT_ALWAYS;
            c.done    = 1'b1;
         end
         UA_SUB: begin
            c.res_sel = RES_SUB;
            c.emit    = EMIT_ALWAYS;
            c.done    = 1'b1;
         end
         UA_NEG: begin
            c.res_sel = RES_NEG;
            c.emit    = EMIT_ALWAYS;
            c.done    = 1'b1;
         end
         UA_MUL: begin
            c.mul_sel = MUL_XY;
         end
         UA_FOLD: begin
            c.res_sel = RES_FOLD;
            c.emit    = EMIT_ALWAYS;
            c.done    = 1'b1;
         end
         UA_DOT_MUL: begin
            c.mul_sel = MUL_XY;
         end
         UA_DOT_FOLD: begin
            c.fold_dst = FOLD_ACC;
         end
         UA_DOT_SUM: begin
            c.res_sel = RES_DOT;
            c.emit    = EMIT_IF_LAST;
            c.sum_wr  = 1'b1;
            c.done    = 1'b1;
         end
         UA_INV_INIT: begin
            c.inv_init = 1'b1;
         end
         UA_INV_TOP: begin
            c.cond   = COND_BIT_CLEAR;
            c.target = UA_INV_SQ;
         end
         UA_INV_MUL: begin
            c.mul_sel = MUL_ACC_BASE;
         end
         UA_INV_FOLD_ACC: begin
            c.fold_dst = FOLD_ACC;
         end
         UA_INV_SQ: begin
            c.mul_sel = MUL_BASE_BASE;
            c.cond    = COND_LAST_BIT;
            c.target  = UA_INV_DONE;
         end
         UA_INV_FOLD_BASE: begin
            c.fold_dst = FOLD_BASE;
            c.cnt_inc  = 1'b1;
            c.cond     = COND_ALWAYS;
            c.target   = UA_INV_TOP;
         end
         UA_INV_DONE: begin
            c.res_sel = RES_ACC;
            c.emit    = EMIT_ALWAYS;
            c.done    = 1'b1;
         end
      endcase
      return c;
   endfunction

   function automatic logic [3:0] dispatch(input logic [2:0] op);
      logic [3:0] a;
      unique case (op)
         OP_ADD:  a = UA_ADD;
         OP_SUB:  a = UA_SUB;
         OP_MUL:  a = UA_MUL;
         OP_NEG:  a = UA_NEG;
         OP_INV:  a = UA_INV_INIT;
         OP_RED:  a = UA_FOLD;
         OP_DOT:  a = UA_DOT_MUL;
         default: a = UA_IDLE;
      endcase
      return a;
   endfunction

   function automatic logic [30:0] fold_wide(input logic [63:0] x);
      logic [33:0] f;
      logic [31:0] r;
      f = {3'b000, x[30:0]} + {1'b0, x[63:31]};
      r = {1'b0, f[30:0]} + {29'd0, f[33:31]};
      if (r >= {1'b0, MODULUS}) begin
         r = r - {1'b0, MODULUS};
      end
      return r[30:0];
   endfunction

   function automatic logic [30:0] fadd(input logic [30:0] x, input logic [30:0] y);
      logic [31:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, MODULUS}) begin
         s = s - {1'b0, MODULUS};
      end
      return s[30:0];
   endfunction

   function automatic logic [30:0] fsub(input logic [30:0] x, input logic [30:0] y);
      logic [31:0] d;
      if (x >= y) begin
         d = {1'b0, x} - {1'b0, y};
      end else begin
         d = {1'b0, x} + {1'b0, MODULUS} - {1'b0, y};
      end
      return d[30:0];
   endfunction

   function automatic logic [30:0] fneg(input logic [30:0] x);
      logic [30:0] n;
      if (x == 31'd0) begin
         n = 31'd0;
      end else begin
         n = MODULUS - x;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/mersenne31_field_alu_with_dot_unit.sv @@
// Microcoded arithmetic unit over the field of integers modulo 2^31 - 1.
`default_nettype none

// The unit takes one request at a time and runs it through a sixteen-word microcode program
// that steers a single 31 by 31 bit multiplier, a Mersenne fold and a modular adder. Of add,
// subtract, negate, reduce, multiply, a dot term and an inverse, the inverse takes longest,
// being bounded by the square-and-multiply loop over the 31 exponent bits on the one
// multiplier. Operation code 7 is taken and dropped with no response. A finished result waits
// in an output register, so a new request is taken while the previous result is still pending.
module mersenne31_field_alu_with_dot_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // Fields from bit 0: operation[2:0], a[30:0], b[30:0], wide_value[63:0], zero padding.
   input  wire logic [135:0] req_tdata,
   // Marks the final dot term.
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // Fields from bit 0: result[30:0], fault[1:0], zero padding.
   output logic [39:0]       rsp_tdata
);
   import m31alu_pkg::*;

   logic [3:0]  pc_ff, pc_in;
   logic [30:0] x_ff, x_in;
   logic [30:0] y_ff, y_in;
   logic [63:0] wide_ff, wide_in;
   logic [30:0] acc_ff, acc_in;
   logic [30:0] base_ff, base_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [30:0] sum_ff, sum_in;
   logic [1:0]  fault_ff, fault_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [30:0] rsp_result_ff, rsp_result_in;
   logic [1:0]  rsp_fault_ff, rsp_fault_in;

   ctrl_type    ctrl;
   logic        idle;
   logic        req_accept;
   logic        emit_now;
   logic        step_go;
   logic        jump;
   logic        exp_bit;
   logic [2:0]  req_op;
   logic [30:0] req_a;
   logic [30:0] req_b;
   logic        bad_a;
   logic        bad_b;
   logic [30:0] map_a;
   logic [30:0] map_b;
   logic [1:0]  req_fault;
   logic [30:0] mul_a;
   logic [30:0] mul_b;
   logic [61:0] product;
   logic [30:0] fold_val;
   logic [30:0] dot_val;
   logic [30:0] res_val;

   assign req_op = req_tdata[2:0];
   assign req_a  = req_tdata[33:3];
   assign req_b  = req_tdata[64:34];
   assign bad_a  = (req_a == MODULUS);
   assign bad_b  = (req_b == MODULUS);
   assign map_a  = bad_a ? 31'd0 : req_a;
   assign map_b  = bad_b ? 31'd0 : req_b;

   always_comb begin
      unique case (req_op)
         OP_NEG:  req_fault = bad_a ? FAULT_EQ_Q : FAULT_NONE;
         OP_INV: begin
            if (bad_a) begin
               req_fault = FAULT_EQ_Q;
            end else if (req_a == 31'd0) begin
               req_fault = FAULT_INV_ZERO;
            end else begin
               req_fault = FAULT_NONE;
            end
         end
         OP_RED:  req_fault = FAULT_NONE;
         default: req_fault = (bad_a || bad_b) ? FAULT_EQ_Q : FAULT_NONE;
      endcase
   end

   assign ctrl       = ucode_rom(pc_ff);
   assign idle       = (pc_ff == UA_IDLE);
   assign req_tready = idle && !reset;
   assign req_accept = req_tvalid && req_tready;
   assign exp_bit    = INV_EXPONENT[cnt_ff];

   always_comb begin
      unique case (ctrl.emit)
         EMIT_ALWAYS:  emit_now = 1'b1;
         EMIT_IF_LAST: emit_now = last_ff;
         default:      emit_now = 1'b0;
      endcase
   end

   assign step_go = !idle && (!emit_now || !rsp_valid_ff || rsp_tready);

   always_comb begin
      unique case (ctrl.cond)
         COND_ALWAYS:    jump = 1'b1;
         COND_BIT_CLEAR: jump = !exp_bit;
         COND_LAST_BIT:  jump = (cnt_ff == INV_LAST_BIT);
         default:        jump = 1'b0;
      endcase
   end

   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_ACC_BASE: begin
            mul_a = acc_ff;
            mul_b = base_ff;
         end
         MUL_BASE_BASE: begin
            mul_a = base_ff;
            mul_b = base_ff;
         end
         default: begin
            mul_a = x_ff;
            mul_b = y_ff;
         end
      endcase
   end

   assign product  = mul_a * mul_b;
   assign fold_val = fold_wide(wide_ff);
   assign dot_val  = fadd(sum_ff, acc_ff);

   always_comb begin
      unique case (ctrl.res_sel)
         RES_SUB:  res_val = fsub(x_ff, y_ff);
         RES_NEG:  res_val = fneg(x_ff);
         RES_FOLD: res_val = fold_val;
         RES_DOT:  res_val = dot_val;
         RES_ACC:  res_val = acc_ff;
         default:  res_val = fadd(x_ff, y_ff);
      endcase
   end

   always_comb begin
      pc_in         = pc_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      wide_in       = wide_ff;
      acc_in        = acc_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      fault_in      = fault_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_result_in = rsp_result_ff;
      rsp_fault_in  = rsp_fault_ff;
      if (req_accept) begin
         pc_in    = dispatch(req_op);
         x_in     = map_a;
         y_in     = map_b;
         wide_in  = req_tdata[128:65];
         fault_in = req_fault;
         last_in  = req_tlast;
      end
      if (step_go) begin
         if (ctrl.done) begin
            pc_in = UA_IDLE;
         end else if (jump) begin
            pc_in = ctrl.target;
         end else begin
            pc_in = pc_ff + 4'd1;
         end
         if (ctrl.mul_sel != MUL_NONE) begin
            wide_in = {2'b00, product};
         end
         unique case (ctrl.fold_dst)
            FOLD_ACC:  acc_in = fold_val;
            FOLD_BASE: base_in = fold_val;
            default: begin
            end
         endcase
         if (ctrl.inv_init) begin
            acc_in  = 31'd1;
            base_in = x_ff;
            cnt_in  = 5'd0;
         end
         if (ctrl.cnt_inc) begin
            cnt_in = cnt_ff + 5'd1;
         end
         if (ctrl.sum_wr) begin
            sum_in = last_ff ? 31'd0 : dot_val;
         end
         if (emit_now) begin
            rsp_valid_in  = 1'b1;
            rsp_result_in = res_val;
            rsp_fault_in  = fault_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= UA_IDLE;
         sum_ff       <= 31'd0;
         cnt_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      wide_ff       <= wide_in;
      acc_ff        <= acc_in;
      base_ff       <= base_in;
      fault_ff      <= fault_in;
      last_ff       <= last_in;
      rsp_result_ff <= rsp_result_in;
      rsp_fault_ff  <= rsp_fault_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_fault_ff, rsp_result_ff};

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the Mersenne-31 field arithmetic unit, with a self-checking request predictor.
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import m31alu_pkg::*;

   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [30:0] result;
      logic [1:0]  fault;
   } field_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [39:0]  rsp_tdata;

   field_result_type expected_results[$];
   logic [30:0]   dot_accum;
   int            send_idle_pct;
   int            rsp_stall_pct;
   int            error_count;
   int unsigned   cycle_count;

   mersenne31_field_alu_with_dot_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic logic [30:0] mod_mul(input logic [30:0] x, input logic [30:0] y);
      logic [63:0] p;
      p = 64'(x) * 64'(y);
      return 31'(p % 64'(MODULUS));
   endfunction

   function automatic logic [30:0] mod_inverse(input logic [30:0] x);
      logic [30:0] acc;
      logic [30:0] base;
      logic [30:0] e;
      acc = 31'd1;
      base = x;
      e = MODULUS - 31'd2;
      for (int i = 0; i < 31; i++) begin
         if (e[i]) begin
            acc = mod_mul(acc, base);
         end
         base = mod_mul(base, base);
      end
      return acc;
   endfunction

   // Works out the response to one accepted request and queues it, if there is one.
   task automatic predict_request(input logic [2:0] op, input logic [30:0] a_raw,
                                  input logic [30:0] b_raw, input logic [63:0] wide,
                                  input logic last);
      logic [30:0]   a;
      logic [30:0]   b;
      logic          bad_a;
      logic          bad_b;
      logic [30:0]   term_sum;
      field_result_type r;
      bad_a = (a_raw == MODULUS);
      bad_b = (b_raw == MODULUS);
      a = bad_a ? 31'd0 : a_raw;
      b = bad_b ? 31'd0 : b_raw;
      r.fault = FAULT_NONE;
      r.result = '0;
      case (op)
         OP_ADD: begin
            r.result = 31'((32'(a) + 32'(b)) % 32'(MODULUS));
            if (bad_a || bad_b) r.fault = FAULT_EQ_Q;
         end
         OP_SUB: begin
            r.result = 31'((32'(a) + 32'(MODULUS) - 32'(b)) % 32'(MODULUS));
            if (bad_a || bad_b) r.fault = FAULT_EQ_Q;
         end
         OP_MUL: begin
            r.result = mod_mul(a, b);
            if (bad_a || bad_b) r.fault = FAULT_EQ_Q;
         end
         OP_NEG: begin
            r.result = 31'((32'(MODULUS) - 32'(a)) % 32'(MODULUS));
            if (bad_a) r.fault = FAULT_EQ_Q;
         end
         OP_INV: begin
            if (a == 31'd0) begin
               r.fault = FAULT_INV_ZERO;
            end else begin
               r.result = mod_inverse(a);
            end
            if (bad_a) r.fault = FAULT_EQ_Q;
         end
         OP_RED: begin
            r.result = 31'(wide % 64'(MODULUS));
         end
         OP_DOT: begin
            term_sum = 31'((32'(dot_accum) + 32'(mod_mul(a, b))) % 32'(MODULUS));
            if (!last) begin
               dot_accum = term_sum;
               return;
            end
            dot_accum = '0;
            r.result = term_sum;
            if (bad_a || bad_b) r.fault = FAULT_EQ_Q;
         end
         default: begin
            return;
         end
      endcase
      expected_results.push_back(r);
   endtask

   // Must be called just after a rising edge; returns at the edge where the request is taken.
   task automatic send_request(input logic [2:0] op, input logic [30:0] a,
                               input logic [30:0] b, input logic [63:0] wide,
                               input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, wide, b, a, op};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predict_request(op, a, b, wide, last);
   endtask

   function automatic logic [30:0] random_operand();
      logic [30:0] v;
      case ($urandom_range(9))
         0: v = 31'd0;
         1: v = MODULUS;
         2: v = MODULUS - 31'd1;
         3: v = 31'd1;
         default: v = 31'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [63:0] random_wide();
      logic [63:0] v;
      case ($urandom_range(9))
         0: v = '1;
         1: v = 64'(MODULUS);
         2: v = 64'(MODULUS) * 64'(MODULUS);
         3: v = 64'($urandom);
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected response: result %0d, fault %0d",
                   rsp_tdata[30:0], rsp_tdata[32:31]);
            error_count++;
         end else begin
            if (rsp_tdata[30:0] !== expected_results[0].result) begin
               $error("result mismatch: expected %0d, actual %0d",
                      expected_results[0].result, rsp_tdata[30:0]);
               error_count++;
            end
            if (rsp_tdata[32:31] !== expected_results[0].fault) begin
               $error("fault mismatch: expected %0d, actual %0d",
                      expected_results[0].fault, rsp_tdata[32:31]);
               error_count++;
            end
            void'(expected_results.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic test_field_arithmetic();
      send_request(OP_ADD, MODULUS - 31'd1, MODULUS - 31'd1, '0, 1'b0);
      send_request(OP_ADD, 31'd0, 31'd0, '1, 1'b1);
      send_request(OP_SUB, 31'd0, MODULUS - 31'd1, '0, 1'b0);
      send_request(OP_SUB, MODULUS - 31'd1, 31'd0, '0, 1'b0);
      send_request(OP_MUL, MODULUS - 31'd1, MODULUS - 31'd1, '0, 1'b0);
      send_request(OP_ADD, MODULUS, 31'd5, '0, 1'b0);
      send_request(OP_MUL, 31'd3, MODULUS, '0, 1'b0);
      send_request(OP_SUB, MODULUS, MODULUS, '0, 1'b0);
      send_request(OP_NEG, 31'd0, 31'd9, '0, 1'b0);
      send_request(OP_NEG, MODULUS - 31'd1, MODULUS, '0, 1'b0);
      send_request(OP_NEG, MODULUS, 31'd0, '0, 1'b0);
   endtask

   task automatic test_inverse();
      send_request(OP_INV, 31'd0, 31'd0, '0, 1'b0);
      send_request(OP_INV, 31'd1, MODULUS, '0, 1'b0);
      send_request(OP_INV, MODULUS - 31'd1, 31'd0, '0, 1'b0);
      send_request(OP_INV, MODULUS, 31'd0, '0, 1'b0);
      send_request(OP_INV, 31'd2, 31'd0, '0, 1'b0);
   endtask

   task automatic test_wide_reduction();
      send_request(OP_RED, MODULUS, MODULUS, '0, 1'b0);
      send_request(OP_RED, MODULUS, MODULUS, '1, 1'b1);
      send_request(OP_RED, 31'd0, 31'd0, 64'(MODULUS), 1'b0);
      send_request(OP_RED, 31'd0, 31'd0, 64'h7fff_ffff_8000_0000, 1'b0);
   endtask

   task automatic test_dot_product();
      send_request(OP_DOT, MODULUS - 31'd1, MODULUS - 31'd1, '0, 1'b0);
      send_request(OP_DOT, MODULUS, 31'd7, '0, 1'b0);
      send_request(OP_UNUSED, 31'd3, 31'd4, '1, 1'b1);
      send_request(OP_DOT, 31'd12345, MODULUS, '0, 1'b1);
      send_request(OP_DOT, 31'd6, 31'd7, '0, 1'b1);
   endtask

   task automatic test_random_traffic(input int n_items, input int idle_pct,
                                      input int stall_pct);
      int          sent;
      int          len;
      int          pick;
      logic [2:0]  op;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               send_request(OP_DOT, random_operand(), random_operand(), random_wide(),
                            i == len - 1);
            end
            sent += len;
         end else if (pick < 40) begin
            op = 3'($urandom_range(7));
            send_request(op, random_operand(), random_operand(), random_wide(),
                         1'($urandom_range(1)));
            if (op != OP_UNUSED) sent++;
         end else if (pick < 45) begin
            send_request(OP_INV, random_operand(), random_operand(), random_wide(),
                         1'($urandom_range(1)));
            sent++;
         end else begin
            case ($urandom_range(4))
               0: op = OP_ADD;
               1: op = OP_SUB;
               2: op = OP_MUL;
               3: op = OP_NEG;
               default: op = OP_RED;
            endcase
            send_request(op, random_operand(), random_operand(), random_wide(),
                         1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   initial begin
      dot_accum = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      error_count = 0;
      cycle_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_arithmetic();
      test_inverse();
      test_wide_reduction();
      test_dot_product();
      test_random_traffic(325, 0, 0);
      test_random_traffic(325, 74, 0);
      test_random_traffic(325, 0, 74);
      test_random_traffic(325, 30, 30);
      req_tvalid <= 1'b0;
      rsp_stall_pct = 0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
